[rtl/core/pwm_pkg.sv]
package pwm_pkg;

    // Character codes
    localparam logic [7:0] CHAR_NUL   = 8'd0;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    // Configuration register indexes
    localparam logic [1:0] REG_LETTERS_LOW  = 2'd0;
    localparam logic [1:0] REG_LETTERS_HIGH = 2'd1;
    localparam logic [1:0] REG_LENGTH       = 2'd2;

    localparam int unsigned LETTERS_PER_REG = 8;

    // Search phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_SKIP = 3'b010,
        PH_WORD = 3'b100
    } pwm_phase_t;

    // Handed from each cell to the next along the chain
    typedef struct packed {
        logic taken;        // an earlier cell claims this character
        logic all_claimed;  // every earlier letter in use is claimed
    } pwm_link_t;

endpackage

[rtl/core/pwm_cell.sv]
module pwm_cell
    import pwm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [7:0] letter,
    input  logic      active,
    input  logic [7:0] text_char,
    input  logic      clear,
    input  logic      claim_en,
    input  pwm_link_t link_in,
    output pwm_link_t link_out,
    output logic      claimed
);

    logic claimed_reg;
    logic claimed_next;
    logic claimed_eff;
    logic hit;

    // a new search clears the claim before this character is compared
    assign claimed_eff = claimed_reg && !clear;
    assign hit         = active && !claimed_eff && (letter == text_char);

    assign link_out.taken       = link_in.taken || hit;
    assign link_out.all_claimed = link_in.all_claimed && (claimed_eff || !active);
    assign claimed              = claimed_reg;

    always_comb
    begin
        claimed_next = claimed_eff;
        if (claim_en && hit && !link_in.taken)
        begin
            claimed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            claimed_reg <= 1'b0;
        end
        else
        begin
            claimed_reg <= claimed_next;
        end
    end

endmodule

[rtl/core/permutation_word_matcher_core.sv]
// Channel  | Handshake            | Payload              | Direction
// ---------+----------------------+----------------------+----------
// in       | in_valid / in_ready  | text_char, begin_req | to block
// out      | out_valid / out_ready| found, advance       | from block
// cfg      | cfg_we               | cfg_addr, cfg_data   | to block
//
// One character is taken per cycle; its result, if any, appears in the output
// register on the next cycle. The figure is set by the letter chain: all
// cells compare in parallel and the claim priority ripples through them
// within that cycle. in_ready drops only while a result waits untaken.
// Reset clears claims, phase, count, output valid and the target registers.
module permutation_word_matcher_core
    import pwm_pkg::*;
#(
    parameter int unsigned MAX_LETTERS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_char,
    input  logic        begin_req,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [15:0] advance,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [63:0] cfg_data
);

    localparam logic [4:0] MAX_LEN = 5'(MAX_LETTERS);

    // Target word
    logic [7:0] letters_reg [MAX_LETTERS];
    logic [4:0] length_reg;
    logic [4:0] letters_in_use;

    // Search state
    pwm_phase_t phase_reg, phase_next;
    logic [15:0] consumed_reg, consumed_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    logic        found_reg, found_next;
    logic [15:0] advance_reg, advance_next;

    // Step decode
    logic        accept;
    logic        blank;
    logic        nul;
    pwm_phase_t  phase_eff;
    logic [15:0] consumed_eff;
    logic [15:0] consumed_bump;
    logic        in_word;
    logic        claim_en;
    logic        emit;

    pwm_link_t             link [MAX_LETTERS + 1];
    logic [MAX_LETTERS-1:0] claimed_vec;

    // ---------------------------------------------------------------
    // Configuration: split the 64-bit words into the cells' letters
    // ---------------------------------------------------------------
    for (genvar k = 0; k < MAX_LETTERS; k++)
    begin : g_letter
        localparam logic [1:0] REG_IDX = (k < LETTERS_PER_REG) ? REG_LETTERS_LOW
                                                               : REG_LETTERS_HIGH;
        localparam int unsigned LSB = (k % LETTERS_PER_REG) * 8;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                letters_reg[k] <= 8'd0;
            end
            else if (cfg_we && (cfg_addr == REG_IDX))
            begin
                letters_reg[k] <= cfg_data[LSB +: 8];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= 5'd0;
        end
        else if (cfg_we && (cfg_addr == REG_LENGTH))
        begin
            length_reg <= cfg_data[4:0];
        end
    end

    // a length above the cell count acts as the cell count
    assign letters_in_use = (length_reg > MAX_LEN) ? MAX_LEN : length_reg;

    // ---------------------------------------------------------------
    // Step decode
    // ---------------------------------------------------------------
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign blank    = (text_char == CHAR_SPACE) || (text_char == CHAR_TAB);
    assign nul      = (text_char == CHAR_NUL);

    // begin drops any running search and restarts at this character
    assign phase_eff     = begin_req ? PH_SKIP : phase_reg;
    assign consumed_eff  = begin_req ? 16'd0 : consumed_reg;
    assign consumed_bump = (consumed_eff == 16'hFFFF) ? consumed_eff
                                                      : consumed_eff + 16'd1;

    assign in_word  = ((phase_eff == PH_SKIP) && !blank && !nul) || (phase_eff == PH_WORD);
    assign claim_en = accept && in_word && !blank && !nul;

    // ---------------------------------------------------------------
    // Chain of letter cells; the first unclaimed match wins
    // ---------------------------------------------------------------
    assign link[0] = '{taken: 1'b0, all_claimed: 1'b1};

    for (genvar k = 0; k < MAX_LETTERS; k++)
    begin : g_cell
        localparam logic [4:0] CELL_IDX = 5'(k);

        pwm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .letter    (letters_reg[k]),
            .active    (CELL_IDX < letters_in_use),
            .text_char (text_char),
            .clear     (accept && begin_req),
            .claim_en  (claim_en),
            .link_in   (link[k]),
            .link_out  (link[k + 1]),
            .claimed   (claimed_vec[k])
        );
    end

    // ---------------------------------------------------------------
    // Search sequencing
    // ---------------------------------------------------------------
    always_comb
    begin
        phase_next    = phase_reg;
        consumed_next = consumed_reg;
        emit          = 1'b0;
        found_next    = found_reg;
        advance_next  = advance_reg;

        if (accept)
        begin
            phase_next    = phase_eff;
            consumed_next = consumed_eff;
            unique case (phase_eff)
                PH_SKIP:
                begin
                    if (blank)
                    begin
                        consumed_next = consumed_bump;
                    end
                    else if (nul)
                    begin
                        emit       = 1'b1;
                        found_next = 1'b0;
                    end
                end
                PH_WORD, PH_IDLE:
                begin
                end
                default:
                begin
                end
            endcase

            if (in_word)
            begin
                if (blank || nul)
                begin
                    emit       = 1'b1;
                    found_next = link[MAX_LETTERS].all_claimed;
                end
                else if (link[MAX_LETTERS].taken)
                begin
                    consumed_next = consumed_bump;
                    phase_next    = PH_WORD;
                end
                else
                begin
                    emit       = 1'b1;
                    found_next = 1'b0;
                end
            end

            if (emit)
            begin
                phase_next   = PH_IDLE;
                advance_next = found_next ? consumed_eff : 16'd0;
            end
        end
    end

    // hold the result until it is taken; a new one may replace it on transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            consumed_reg  <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            consumed_reg  <= consumed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg   <= found_next;
        advance_reg <= advance_next;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign advance   = advance_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(phase_reg))
        else $error("search phase lost its one-hot code");

    a_fail_zero_advance: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> advance == 16'd0)
        else $error("failed search reports a non-zero advance");

    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid && (phase_reg == PH_IDLE))
        else $error("result did not end the search");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while a result waits");

    a_idle_no_claim: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) && accept && !begin_req |=> claimed_vec == $past(claimed_vec))
        else $error("claims changed while idle");

endmodule

[test/permutation_word_matcher_core_tb.sv]
`timescale 1ns / 100ps

module permutation_word_matcher_core_tb
    import pwm_pkg::*;
();

    localparam int QUIET_LIMIT     = 2000;  // cycles with no transfer before giving up
    localparam int ITEMS_PER_PHASE = 215;
    localparam int RANDOM_PHASES   = 9;
    localparam int HOLD_CYCLES     = 400;
    localparam int N_STEPS         = 30;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  text_char;
    logic        begin_req;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [15:0] advance;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [63:0] cfg_data;

    permutation_word_matcher_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .text_char (text_char),
        .begin_req (begin_req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .found     (found),
        .advance   (advance),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Search tracker: our own copy of the target registers and of the
    // matcher's state, stepped once per accepted character.
    // ------------------------------------------------------------------
    logic [63:0] tgt_low  = '0;
    logic [63:0] tgt_high = '0;
    logic [4:0]  tgt_len  = '0;
    logic        held_claims [16];
    pwm_phase_t  search_phase = PH_IDLE;
    logic [15:0] run_length = '0;

    typedef struct packed {
        logic        found;
        logic [15:0] advance;
    } verdict_t;

    verdict_t pending_verdicts [$];   // oldest first

    int  mismatches  = 0;
    int  items_sent  = 0;
    int  quiet_cycles = 0;
    bit  steady      = 1'b0;          // both sides stop idling while set
    bit  hold_req    = 1'b0;          // ask the receiver for one long hold-off
    bit  hold_done   = 1'b0;
    int  hold_left   = 0;
    verdict_t want;

    initial
    begin
        for (int k = 0; k < 16; k++)
            held_claims[k] = 1'b0;
    end

    function automatic logic [7:0] target_letter(input int k);
        return (k < LETTERS_PER_REG) ? tgt_low[k*8 +: 8] : tgt_high[(k-8)*8 +: 8];
    endfunction

    // Saturating count of characters consumed since the start point
    function automatic void bump_run();
        if (run_length != 16'hFFFF)
            run_length = run_length + 16'd1;
    endfunction

    // Step the tracker by one character; report whether it ends the search
    function automatic void track_char(input logic [7:0] c, input logic b,
                                       output logic emitted, output verdict_t v);
        logic blank;
        int   n;
        blank   = (c == CHAR_SPACE) || (c == CHAR_TAB);
        emitted = 1'b0;
        v       = '0;
        // A begin drops whatever search was running
        if (b)
        begin
            for (int k = 0; k < 16; k++)
                held_claims[k] = 1'b0;
            run_length   = '0;
            search_phase = PH_SKIP;
        end
        if (search_phase == PH_SKIP)
        begin
            if (blank)
            begin
                bump_run();
                return;
            end
            if (c == CHAR_NUL)
            begin
                // string ended before any word began
                emitted      = 1'b1;
                search_phase = PH_IDLE;
                return;
            end
            search_phase = PH_WORD;
        end
        // Idle without begin: character ignored
        if (search_phase != PH_WORD)
            return;
        // Length above the letter count acts as the full count
        n = (tgt_len > 5'd16) ? 16 : int'(tgt_len);
        if (blank || c == CHAR_NUL)
        begin
            v.found = 1'b1;
            for (int k = 0; k < n; k++)
                if (!held_claims[k])
                    v.found = 1'b0;
            v.advance    = v.found ? run_length : 16'd0;
            emitted      = 1'b1;
            search_phase = PH_IDLE;
            return;
        end
        // Claim the lowest unclaimed equal letter; claimed ones never match
        for (int k = 0; k < n; k++)
        begin
            if (!held_claims[k] && target_letter(k) == c)
            begin
                held_claims[k] = 1'b1;
                bump_run();
                return;
            end
        end
        emitted      = 1'b1;
        search_phase = PH_IDLE;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one character, hold it until the transfer, then log what it
    // should produce. A typed verdict overrides the tracker's one.
    task automatic offer(input logic [7:0] c, input logic b, input bit typed,
                         input verdict_t typed_v);
        logic     emitted;
        verdict_t v;
        if (!steady)
        begin
            while ($urandom_range(0, 99) < 36)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        text_char <= c;
        begin_req <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        track_char(c, b, emitted, v);
        if (typed)
            pending_verdicts.push_back(typed_v);
        else if (emitted)
            pending_verdicts.push_back(v);
        items_sent++;
    endtask

    // Drop valid and let the block drain before touching its registers
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_LETTERS_LOW:  tgt_low  = val;
            REG_LETTERS_HIGH: tgt_high = val;
            REG_LENGTH:       tgt_len  = val[4:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Directed plan. Verdicts are typed in where they are plain to see;
    // rows without one rely on the tracker (mostly: no result at all).
    // ------------------------------------------------------------------
    typedef enum bit { STEP_ITEM, STEP_CFG } step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        logic [7:0]  ch;
        logic        bg;
        bit          typed;
        logic        f;
        logic [15:0] adv;
        logic [1:0]  addr;
        logic [63:0] data;
    } step_t;

    step_t plan [N_STEPS] = '{
        // empty target straight after reset: first word character fails
        '{STEP_ITEM, "a",        1'b1, 1'b1, 1'b0, 16'd0, '0, '0},
        // idle and no begin: ignored
        '{STEP_ITEM, "x",        1'b0, 1'b0, 1'b0, 16'd0, '0, '0},
        // string ends before a word
        '{STEP_ITEM, CHAR_NUL,   1'b1, 1'b1, 1'b0, 16'd0, '0, '0},
        // blanks after blanks keep skipping, NUL then fails
        '{STEP_ITEM, CHAR_SPACE, 1'b1, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, CHAR_TAB,   1'b0, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, CHAR_NUL,   1'b0, 1'b1, 1'b0, 16'd0, '0, '0},
        // target "stop", letter 4 is a bell byte kept out of use for now
        '{STEP_CFG,  CHAR_NUL,   1'b0, 1'b0, 1'b0, 16'd0, REG_LETTERS_LOW,
          64'h0000_0007_706F_7473},
        '{STEP_CFG,  CHAR_NUL,   1'b0, 1'b0, 1'b0, 16'd0, REG_LENGTH, 64'd4},
        '{STEP_ITEM, "p",        1'b1, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, "o",        1'b0, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, "t",        1'b0, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, "s",        1'b0, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, CHAR_SPACE, 1'b0, 1'b1, 1'b1, 16'd4, '0, '0},
        // a claimed letter never matches again
        '{STEP_ITEM, CHAR_TAB,   1'b1, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, "o",        1'b0, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, "o",        1'b0, 1'b1, 1'b0, 16'd0, '0, '0},
        // begin in the middle of a word drops it silently
        '{STEP_ITEM, "t",        1'b1, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, "o",        1'b0, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, "s",        1'b1, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, "t",        1'b0, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, "o",        1'b0, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, "p",        1'b0, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, CHAR_NUL,   1'b0, 1'b1, 1'b1, 16'd4, '0, '0},
        // oversized length acts as sixteen; upper letters all ones
        '{STEP_CFG,  CHAR_NUL,   1'b0, 1'b0, 1'b0, 16'd0, REG_LETTERS_HIGH, '1},
        '{STEP_CFG,  CHAR_NUL,   1'b0, 1'b0, 1'b0, 16'd0, REG_LENGTH, 64'd31},
        // the bell byte claims its one letter, then finds nothing left
        '{STEP_ITEM, 8'h07,      1'b1, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, 8'h07,      1'b0, 1'b1, 1'b0, 16'd0, '0, '0},
        // partial word at the terminator fails
        '{STEP_ITEM, "p",        1'b1, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, 8'hFF,      1'b0, 1'b0, 1'b0, 16'd0, '0, '0},
        '{STEP_ITEM, CHAR_TAB,   1'b0, 1'b1, 1'b0, 16'd0, '0, '0}
    };

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial
    begin
        logic [7:0]  lt [16];
        logic [7:0]  seq [$];
        int          order [16];
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        int          n;
        int          lead;
        int          j;
        int          tmp;
        int          r;
        int          goal;
        bit          wellformed;
        logic        b;

        in_valid  = 1'b0;
        text_char = CHAR_NUL;
        begin_req = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_LETTERS_LOW;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed plan
        for (int s = 0; s < N_STEPS; s++)
        begin
            if (plan[s].kind == STEP_CFG)
            begin
                settle();
                write_reg(plan[s].addr, plan[s].data);
            end
            else
                offer(plan[s].ch, plan[s].bg, plan[s].typed, '{plan[s].f, plan[s].adv});
        end

        // Random phases, each with its own target setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            case (p)
                0:       len = 5'($urandom_range(1, 8));
                1:       len = 5'd16;
                2:       len = 5'd0;
                3:       len = 5'd31;
                4:       len = 5'($urandom_range(0, 16));
                5:       len = 5'($urandom_range(1, 16));
                6:       len = 5'($urandom_range(17, 30));
                7:       len = 5'd16;
                default: len = 5'($urandom_range(1, 16));
            endcase
            for (int k = 0; k < 16; k++)
            begin
                case (p)
                    1:       lt[k] = 8'hFF;
                    2, 5:    lt[k] = 8'($urandom_range(1, 255));
                    3:       lt[k] = 8'($urandom_range(0, 255));
                    4:       lt[k] = 8'("a" + $urandom_range(0, 3));
                    6:       lt[k] = 8'("x" + $urandom_range(0, 1));
                    7:       lt[k] = 8'h00;
                    default: lt[k] = 8'("a" + $urandom_range(0, 2));
                endcase
            end
            for (int k = 0; k < 8; k++)
            begin
                lo[k*8 +: 8] = lt[k];
                hi[k*8 +: 8] = lt[k+8];
            end
            write_reg(REG_LETTERS_LOW, lo);
            write_reg(REG_LETTERS_HIGH, hi);
            write_reg(REG_LENGTH, 64'(len));
            steady = (p == 4);
            if (p == 5)
                hold_req = 1'b1;
            n = (len > 5'd16) ? 16 : int'(len);

            goal = items_sent + ITEMS_PER_PHASE;
            while (items_sent < goal)
            begin
                seq.delete();
                r = $urandom_range(0, 99);
                wellformed = (r < 75);
                if (wellformed)
                begin
                    lead = $urandom_range(0, 3);
                    repeat (lead)
                        seq.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
                    // shuffle the letters in use into a candidate word
                    for (int k = 0; k < n; k++)
                        order[k] = k;
                    for (int k = n - 1; k > 0; k--)
                    begin
                        j        = $urandom_range(0, k);
                        tmp      = order[k];
                        order[k] = order[j];
                        order[j] = tmp;
                    end
                    for (int k = 0; k < n; k++)
                        seq.push_back(lt[order[k]]);
                    // spoil some of them
                    case ($urandom_range(0, 9))
                        0: if (n > 0) void'(seq.pop_back());
                        1: if (n > 0) seq.push_back(lt[$urandom_range(0, n - 1)]);
                        2: if (n > 0) seq[lead + $urandom_range(0, n - 1)] =
                               8'($urandom_range(0, 255));
                        3: seq.push_back(8'("a" + $urandom_range(0, 2)));
                        default: ;
                    endcase
                    // a few sequences break off without a terminator
                    if (r < 70 || seq.size() == 0)
                    begin
                        case ($urandom_range(0, 2))
                            0:       seq.push_back(CHAR_SPACE);
                            1:       seq.push_back(CHAR_TAB);
                            default: seq.push_back(CHAR_NUL);
                        endcase
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, 6))
                        seq.push_back(8'($urandom_range(0, 255)));
                end
                for (int k = 0; k < seq.size(); k++)
                begin
                    if (wellformed)
                        b = (k == 0);
                    else
                        b = ($urandom_range(0, 3) == 0);
                    offer(seq[k], b, 1'b0, '0);
                end
            end
        end

        // Drain, then give the output register time to show any stray result
        settle();
        steady = 1'b0;
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("permutation_word_matcher_core_tb passed");
        else
            $display("permutation_word_matcher_core_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, a steady stretch, and one long hold-off
    // counted here so that the block backs up and drops in_ready.
    // ------------------------------------------------------------------
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= steady || ($urandom_range(0, 99) >= 36);
        end
    end

    // ------------------------------------------------------------------
    // Result check and watchdog
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got found=%0d advance=%0d",
                             $realtime, found, advance);
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (found !== want.found)
                    begin
                        mismatches++;
                        $display("%0t: found mismatch, expected %0d, got %0d",
                                 $realtime, want.found, found);
                    end
                    if (advance !== want.advance)
                    begin
                        mismatches++;
                        $display("%0t: advance mismatch, expected %0d, got %0d",
                                 $realtime, want.advance, advance);
                    end
                end
            end
            // Count cycles in which neither channel moves a transfer
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
                    $display("permutation_word_matcher_core_tb failed");
                    $finish;
                end
            end
        end
    end

endmodule

[permutation_word_matcher_core.f]
rtl/core/pwm_pkg.sv
rtl/core/pwm_cell.sv
rtl/core/permutation_word_matcher_core.sv
test/permutation_word_matcher_core_tb.sv
